>>> rtl/core/i2a_pkg.sv
package i2a_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOWA  = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_X     = 8'h78;

    localparam logic [3:0] DEC_RADIX = 4'd10;

    localparam logic KIND_DEC = 1'b0;
    localparam logic KIND_HEX = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_CONVERT = 5'b00010,
        ST_PREFIX  = 5'b00100,
        ST_SKIP    = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    // Maps one digit (0 to 15) to its lowercase ASCII code.
    function automatic logic [7:0] to_ascii(input logic [3:0] digit);
        logic [7:0] wide;
        wide = {4'b0000, digit};
        if (digit < DEC_RADIX) begin
            return CHAR_ZERO + wide;
        end else begin
            return CHAR_LOWA + wide - {4'b0000, DEC_RADIX};
        end
    endfunction

endpackage

>>> rtl/core/i2a_dabble.sv
// One shift-and-add-3 step: every BCD digit of 5 or more gets 3 added, then
// the whole word moves left by one bit and takes in the next binary bit.
module i2a_dabble #(
    parameter int NDIG = 10
) (
    input  logic [NDIG*4-1:0] bcd_in,
    input  logic              bit_in,
    output logic [NDIG*4-1:0] bcd_out
);

    logic [NDIG*4-1:0] adjusted;

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_in[i*4 +: 4] >= 4'd5) begin
                adjusted[i*4 +: 4] = bcd_in[i*4 +: 4] + 4'd3;
            end else begin
                adjusted[i*4 +: 4] = bcd_in[i*4 +: 4];
            end
        end
    end

    assign bcd_out = {adjusted[NDIG*4-2:0], bit_in};

endmodule

>>> rtl/core/integer_to_ascii_formatter.sv
// Flow: a decimal value runs through ST_CONVERT, which takes in one bit of the
// value per step, then ST_PREFIX for a '-' if negative, ST_SKIP to drop leading
// zeros (keeping the final digit) and ST_EMIT, one character per step.
// A hex value skips the converter; it passes ST_PREFIX for "0x", ST_SKIP, ST_EMIT.
// s_axis_tready is high only when idle, so a new value is taken only after the
// last character of the previous one is issued. Reset (aresetn low, synchronous)
// returns to idle and drops m_axis_tvalid.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = i2a_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: value[VALUE_WIDTH-1:0], zero padding up to a whole byte
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    // tuser: kind (0 = signed decimal, 1 = hexadecimal)
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: character[7:0]
    output logic [7:0]                            m_axis_tdata,
    output logic                                  m_axis_tlast
);

    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int DIG_W = NDIG * 4;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    i2a_pkg::state_t state_reg, state_next;

    logic                   kind_reg, kind_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [DIG_W-1:0]       digits_reg, digits_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [1:0]             pre_reg, pre_next;
    logic [7:0]             char_reg, char_next;
    logic                   last_reg, last_next;
    logic                   ovalid_reg, ovalid_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic [DIG_W-1:0]       dabble_out;
    logic [3:0]             top_digit;
    logic                   out_free;

    assign in_value  = s_axis_tdata[VALUE_WIDTH-1:0];
    assign top_digit = digits_reg[DIG_W-1 -: 4];
    assign out_free  = !ovalid_reg || m_axis_tready;

    i2a_dabble #(
        .NDIG (NDIG)
    ) u_dabble (
        .bcd_in  (digits_reg),
        .bit_in  (bin_reg[VALUE_WIDTH-1]),
        .bcd_out (dabble_out)
    );

    always_comb begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        neg_next    = neg_reg;
        bin_next    = bin_reg;
        digits_next = digits_reg;
        cnt_next    = cnt_reg;
        pre_next    = pre_reg;
        char_next   = char_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg;

        if (m_axis_tready) begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            i2a_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    kind_next = s_axis_tuser;
                    if (s_axis_tuser == i2a_pkg::KIND_HEX) begin
                        neg_next    = 1'b0;
                        digits_next = {{(DIG_W-VALUE_WIDTH){1'b0}}, in_value};
                        cnt_next    = CNT_W'(NDIG);
                        pre_next    = 2'd2;
                        state_next  = i2a_pkg::ST_PREFIX;
                    end else begin
                        neg_next    = in_value[VALUE_WIDTH-1];
                        // The most negative value negates to itself, which
                        // read as unsigned is exactly its magnitude.
                        bin_next    = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1)
                                                              : in_value;
                        digits_next = '0;
                        cnt_next    = CNT_W'(VALUE_WIDTH);
                        pre_next    = 2'd1;
                        state_next  = i2a_pkg::ST_CONVERT;
                    end
                end
            end
            i2a_pkg::ST_CONVERT: begin
                digits_next = dabble_out;
                bin_next    = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next    = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    cnt_next   = CNT_W'(NDIG);
                    state_next = neg_reg ? i2a_pkg::ST_PREFIX : i2a_pkg::ST_SKIP;
                end
            end
            i2a_pkg::ST_PREFIX: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    last_next   = 1'b0;
                    if (kind_reg == i2a_pkg::KIND_HEX) begin
                        char_next = (pre_reg == 2'd2) ? i2a_pkg::CHAR_ZERO
                                                      : i2a_pkg::CHAR_X;
                    end else begin
                        char_next = i2a_pkg::CHAR_MINUS;
                    end
                    pre_next = pre_reg - 1'b1;
                    if (pre_reg == 2'd1) begin
                        state_next = i2a_pkg::ST_SKIP;
                    end
                end
            end
            i2a_pkg::ST_SKIP: begin
                // Drop leading zeros, but always keep the final digit.
                if (top_digit == 4'd0 && cnt_reg != CNT_W'(1)) begin
                    digits_next = {digits_reg[DIG_W-5:0], 4'b0000};
                    cnt_next    = cnt_reg - 1'b1;
                end else begin
                    state_next = i2a_pkg::ST_EMIT;
                end
            end
            i2a_pkg::ST_EMIT: begin
                if (out_free) begin
                    ovalid_next = 1'b1;
                    char_next   = i2a_pkg::to_ascii(top_digit);
                    last_next   = (cnt_reg == CNT_W'(1));
                    digits_next = {digits_reg[DIG_W-5:0], 4'b0000};
                    cnt_next    = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = i2a_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = i2a_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= i2a_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        neg_reg    <= neg_next;
        bin_reg    <= bin_next;
        digits_reg <= digits_next;
        cnt_reg    <= cnt_next;
        pre_reg    <= pre_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
    end

    assign s_axis_tready = (state_reg == i2a_pkg::ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = char_reg;
    assign m_axis_tlast  = last_reg;

endmodule

>>> rtl/core/i2a_checker.sv
module i2a_checker #(
    parameter int VALUE_WIDTH = i2a_pkg::DEFAULT_VALUE_WIDTH
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [7:0]                       m_axis_tdata,
    input logic                             m_axis_tlast
);

    // A held result transaction keeps its character and flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // One value is formatted at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // When a new value is taken, anything still pending is the previous end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid || m_axis_tlast)
        else $error("new value accepted mid-text");

    // Only digits, lowercase hex letters, '-' and 'x' are ever produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            (m_axis_tdata >= i2a_pkg::CHAR_ZERO && m_axis_tdata <= 8'h39) ||
            (m_axis_tdata >= i2a_pkg::CHAR_LOWA && m_axis_tdata <= 8'h66) ||
            m_axis_tdata == i2a_pkg::CHAR_MINUS || m_axis_tdata == i2a_pkg::CHAR_X)
        else $error("unexpected output character");

    // An offered input transaction carries known data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid |-> !$isunknown({s_axis_tuser, s_axis_tdata}))
        else $error("unknown input transaction");

endmodule

bind integer_to_ascii_formatter i2a_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_i2a_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

>>> verif/tb_integer_to_ascii_formatter.sv
module tb_integer_to_ascii_formatter;

    localparam int WORD_BITS = 32;

    typedef struct {
        logic                 kind;
        logic [WORD_BITS-1:0] value;
        int                   gap;
    } word_item_t;

    typedef struct {
        logic [7:0] character;
        logic       last;
    } text_char_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // tdata: value[31:0]
    logic [WORD_BITS-1:0] s_axis_tdata = '0;
    // tuser: kind
    logic                 s_axis_tuser = i2a_pkg::KIND_DEC;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // tdata: character[7:0]
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;

    word_item_t pending_words[$];
    text_char_t expected_chars[$];
    int         mismatch_count = 0;
    int         word_gap = 0;
    int         ready_hold = 0;
    int         cycle_count = 0;

    integer_to_ascii_formatter #(
        .VALUE_WIDTH(WORD_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 aclk = ~aclk;

    // Builds the text of one word and appends its characters to the
    // expected queue, most significant character first.
    task automatic predict_text(input logic kind, input logic [WORD_BITS-1:0] value);
        logic [7:0]           text[$];
        logic [7:0]           digits_rev[$];
        logic [WORD_BITS-1:0] mag;
        logic [WORD_BITS-1:0] radix;
        logic [WORD_BITS-1:0] digit;
        text_char_t           entry;
        int                   i;
        mag = value;
        if (kind == i2a_pkg::KIND_HEX) begin
            radix = 16;
            text.push_back(i2a_pkg::CHAR_ZERO);
            text.push_back(i2a_pkg::CHAR_X);
        end else begin
            radix = 10;
            if (value[WORD_BITS-1]) begin
                text.push_back(i2a_pkg::CHAR_MINUS);
                // Unsigned wrap makes the most negative word its own magnitude.
                mag = ~value + 1'b1;
            end
        end
        do begin
            digit = mag % radix;
            if (digit < 10) begin
                digits_rev.push_back(i2a_pkg::CHAR_ZERO + digit[7:0]);
            end else begin
                digits_rev.push_back(i2a_pkg::CHAR_LOWA + digit[7:0] - 8'd10);
            end
            mag = mag / radix;
        end while (mag != 0);
        for (i = digits_rev.size() - 1; i >= 0; i--) begin
            text.push_back(digits_rev[i]);
        end
        for (i = 0; i < text.size(); i++) begin
            entry.character = text[i];
            entry.last = (i == text.size() - 1);
            expected_chars.push_back(entry);
        end
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(20, 70);
        end
    endfunction

    task automatic queue_word(input logic kind, input logic [WORD_BITS-1:0] value,
                              input bit calm);
        word_item_t item;
        item.kind = kind;
        item.value = value;
        item.gap = pick_gap(calm);
        pending_words.push_back(item);
    endtask

    // Input driver: a new transaction is offered only once the previous one
    // has been taken, after the gap chosen for that item.
    always @(posedge aclk) begin
        word_item_t item;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_text(s_axis_tuser, s_axis_tdata);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (word_gap > 0) begin
                    word_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    item = pending_words.pop_front();
                    s_axis_tdata  <= item.value;
                    s_axis_tuser  <= item.kind;
                    s_axis_tvalid <= 1'b1;
                    word_gap = item.gap;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor with random back-pressure; in the first of every four equal
    // stretches of the cycle counter, tready is kept high once any pause already under way ends.
    always @(posedge aclk) begin
        text_char_t want;
        int         r;
        cycle_count++;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character 0x%02h with last %0b", m_axis_tdata,
                       m_axis_tlast);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (m_axis_tdata !== want.character) begin
                    $error("character: expected 0x%02h, actual 0x%02h", want.character,
                           m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if ((cycle_count % 512) < 128 || r < 55) begin
                m_axis_tready <= 1'b1;
                ready_hold = $urandom_range(0, 4);
            end else if (r < 92) begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(0, 3);
            end else begin
                m_axis_tready <= 1'b0;
                ready_hold = $urandom_range(15, 60);
            end
        end
    end

    initial begin
        logic [WORD_BITS-1:0] value;
        logic [WORD_BITS-1:0] pow10;
        bit                   calm;
        int                   n;
        int                   r;

        // Zero, one-digit and carry boundaries, and the signed extremes.
        queue_word(i2a_pkg::KIND_DEC, 32'd0, 1'b0);
        queue_word(i2a_pkg::KIND_HEX, 32'd0, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'd1, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'hFFFF_FFFF, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'd9, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'd10, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, -32'sd10, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'h7FFF_FFFF, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'h8000_0000, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'h8000_0001, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'd1000000000, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'd999999999, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, -32'sd999999999, 1'b0);
        queue_word(i2a_pkg::KIND_DEC, 32'd123456789, 1'b0);
        queue_word(i2a_pkg::KIND_HEX, 32'd1, 1'b0);
        queue_word(i2a_pkg::KIND_HEX, 32'hF, 1'b0);
        queue_word(i2a_pkg::KIND_HEX, 32'h10, 1'b0);
        queue_word(i2a_pkg::KIND_HEX, 32'hFFFF_FFFF, 1'b0);
        queue_word(i2a_pkg::KIND_HEX, 32'h8000_0000, 1'b0);
        queue_word(i2a_pkg::KIND_HEX, 32'h7FFF_FFFF, 1'b0);
        queue_word(i2a_pkg::KIND_HEX, 32'hDEAD_BEEF, 1'b0);
        queue_word(i2a_pkg::KIND_HEX, 32'h0000_ABCD, 1'b0);

        calm = 0;
        for (n = 0; n < 98; n++) begin
            if (n % 20 == 0) begin
                calm = ($urandom_range(0, 2) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 65) begin
                value = $urandom;
            end else if (r < 85) begin
                value = $urandom_range(0, 1000);
                if ($urandom_range(0, 1)) begin
                    value = ~value + 1'b1;
                end
            end else begin
                // Around a power of ten, where the digit count changes.
                pow10 = 1;
                repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
                value = pow10 + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) begin
                    value = ~value + 1'b1;
                end
            end
            queue_word(1'($urandom_range(0, 1)), value, calm);
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_words.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
